// ===== src/sha_pkg.sv =====
// Shared types, constants and round functions for the SHA-256 stream hasher.
// Used by sha_core.sv and sha256_stream_hasher_unit.sv; no dependencies.
package sha_pkg;

  typedef logic [7:0][31:0] word8_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD_ONE,
    ST_PAD_ZERO,
    ST_PAD_LEN,
    ST_START,
    ST_COMP,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic start;
  } core_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

  localparam logic [5:0] BlockLast = 6'd63;
  localparam logic [5:0] LenStart  = 6'd56;
  localparam logic [5:0] RoundLast = 6'd63;
  localparam logic [2:0] WordLast  = 3'd7;
  localparam logic [7:0] PadByte   = 8'h80;
  localparam logic [7:0] ZeroByte  = 8'h00;

  localparam word8_t InitChain = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] sm_sig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] sm_sig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

// ===== src/sha_if.sv =====
// Valid/ready channel interfaces for the SHA-256 stream hasher.
// sha_in_if carries message bytes, sha_out_if carries digest words; no dependencies.
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       end_of_message;

  modport source (output valid, data_byte, byte_valid, end_of_message, input ready);
  modport sink   (input valid, data_byte, byte_valid, end_of_message, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== src/sha_core.sv =====
// SHA-256 compression unit: one round per cycle over a 16-word schedule window.
// Depends on sha_pkg for round constants, sigma functions and control structs.
module sha_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sha_pkg::core_ctrl_t ctrl_i,
  input  logic [31:0]         word_i,
  input  sha_pkg::word8_t     chain_i,
  output sha_pkg::core_stat_t stat_o,
  output sha_pkg::word8_t     round_o
);

  logic [31:0]     w_q [16];
  sha_pkg::word8_t r_q;
  logic [5:0]      rnd_q;
  logic            busy_q;
  logic            done_q;

  logic [31:0] w_new;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch;
  logic [31:0] maj;

  always_comb begin
    w_new = w_q[0] + sha_pkg::sm_sig0(w_q[1]) + w_q[9] + sha_pkg::sm_sig1(w_q[14]);
    ch    = (r_q[4] & r_q[5]) ^ (~r_q[4] & r_q[6]);
    maj   = (r_q[0] & r_q[1]) ^ (r_q[0] & r_q[2]) ^ (r_q[1] & r_q[2]);
    t1    = r_q[7] + sha_pkg::big_sig1(r_q[4]) + ch + sha_pkg::RoundK[rnd_q] + w_q[0];
    t2    = sha_pkg::big_sig0(r_q[0]) + maj;
  end

  // Window shifts on every loaded word and on every round.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load || busy_q) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i + 1];
      end
      w_q[15] <= busy_q ? w_new : word_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      r_q <= chain_i;
    end else if (busy_q) begin
      r_q[7] <= r_q[6];
      r_q[6] <= r_q[5];
      r_q[5] <= r_q[4];
      r_q[4] <= r_q[3] + t1;
      r_q[3] <= r_q[2];
      r_q[2] <= r_q[1];
      r_q[1] <= r_q[0];
      r_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rnd_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        rnd_q  <= '0;
      end else if (busy_q) begin
        rnd_q <= rnd_q + 6'd1;
        if (rnd_q == sha_pkg::RoundLast) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign round_o     = r_q;

endmodule

// ===== src/sha256_stream_hasher_unit.sv =====
// SHA-256 byte-stream hasher: message bytes are taken while idle; the byte that fills a block
// starts the round unit (start, 64 rounds, chain add), and input waits until it is done.
// End of message pads one byte per cycle, pausing for each block compression (one or
// two), then drives eight digest words, one per request.
// Reset loads the initial hash values and clears the byte and fill counters.
module sha256_stream_hasher_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  sha_in_if.sink            in_i,
  sha_out_if.source         out_o
);

  sha_pkg::state_e     state_q, state_d;
  sha_pkg::state_e     ret_q, ret_d;
  sha_pkg::word8_t     chain_q;
  sha_pkg::word8_t     round_w;
  sha_pkg::core_ctrl_t core_ctrl;
  sha_pkg::core_stat_t core_stat;

  logic [5:0]  fill_q;
  logic [60:0] cnt_q;
  logic [23:0] acc_q;
  logic [2:0]  idx_q;

  logic        in_acc;
  logic        out_acc;
  logic        push_en;
  logic [7:0]  push_byte;
  logic [7:0][7:0] len_bytes;

  assign in_acc    = in_i.valid && in_i.ready;
  assign out_acc   = out_o.valid && out_o.ready;
  assign len_bytes = {cnt_q, 3'b000};

  // Next state
  always_comb begin
    sha_pkg::state_e after;
    after   = sha_pkg::ST_IDLE;
    state_d = state_q;
    ret_d   = ret_q;
    case (state_q)
      sha_pkg::ST_IDLE: begin
        if (in_acc) begin
          after = in_i.end_of_message ? sha_pkg::ST_PAD_ONE : sha_pkg::ST_IDLE;
          if (in_i.byte_valid && fill_q == sha_pkg::BlockLast) begin
            state_d = sha_pkg::ST_START;
            ret_d   = after;
          end else begin
            state_d = after;
          end
        end
      end
      sha_pkg::ST_PAD_ONE: begin
        if (fill_q == sha_pkg::BlockLast) begin
          state_d = sha_pkg::ST_START;
          ret_d   = sha_pkg::ST_PAD_ZERO;
        end else begin
          state_d = sha_pkg::ST_PAD_ZERO;
        end
      end
      sha_pkg::ST_PAD_ZERO: begin
        if (fill_q == sha_pkg::LenStart) begin
          state_d = sha_pkg::ST_PAD_LEN;
        end else if (fill_q == sha_pkg::BlockLast) begin
          state_d = sha_pkg::ST_START;
          ret_d   = sha_pkg::ST_PAD_ZERO;
        end
      end
      sha_pkg::ST_PAD_LEN: begin
        if (fill_q == sha_pkg::BlockLast) begin
          state_d = sha_pkg::ST_START;
          ret_d   = sha_pkg::ST_OUT;
        end
      end
      sha_pkg::ST_START: begin
        state_d = sha_pkg::ST_COMP;
      end
      sha_pkg::ST_COMP: begin
        if (core_stat.done) begin
          state_d = ret_q;
        end
      end
      sha_pkg::ST_OUT: begin
        if (out_acc && idx_q == sha_pkg::WordLast) begin
          state_d = sha_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sha_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    push_en         = 1'b0;
    push_byte       = sha_pkg::ZeroByte;
    core_ctrl.start = 1'b0;
    in_i.ready      = 1'b0;
    out_o.valid     = 1'b0;
    case (state_q)
      sha_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        push_en    = in_acc && in_i.byte_valid;
        push_byte  = in_i.data_byte;
      end
      sha_pkg::ST_PAD_ONE: begin
        push_en   = 1'b1;
        push_byte = sha_pkg::PadByte;
      end
      sha_pkg::ST_PAD_ZERO: begin
        push_en = (fill_q != sha_pkg::LenStart);
      end
      sha_pkg::ST_PAD_LEN: begin
        push_en   = 1'b1;
        push_byte = len_bytes[~fill_q[2:0]];
      end
      sha_pkg::ST_START: begin
        core_ctrl.start = 1'b1;
      end
      sha_pkg::ST_COMP: begin
      end
      sha_pkg::ST_OUT: begin
        out_o.valid = 1'b1;
      end
      default: begin
      end
    endcase
    core_ctrl.load = push_en && (fill_q[1:0] == 2'b11);
  end

  assign out_o.digest_word = chain_q[idx_q];
  assign out_o.word_index  = idx_q;
  assign out_o.last_word   = (idx_q == sha_pkg::WordLast);

  sha_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (core_ctrl),
    .word_i  ({acc_q, push_byte}),
    .chain_i (chain_q),
    .stat_o  (core_stat),
    .round_o (round_w)
  );

  // Hold three bytes until the fourth completes a word.
  always_ff @(posedge clk_i) begin
    if (push_en) begin
      acc_q <= {acc_q[15:0], push_byte};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha_pkg::ST_IDLE;
      ret_q   <= sha_pkg::ST_IDLE;
      chain_q <= sha_pkg::InitChain;
      fill_q  <= '0;
      cnt_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      if (push_en) begin
        fill_q <= fill_q + 6'd1;
      end
      if (state_q == sha_pkg::ST_IDLE && in_acc && in_i.byte_valid) begin
        cnt_q <= cnt_q + 61'd1;
      end
      if (state_q == sha_pkg::ST_COMP && core_stat.done) begin
        for (int i = 0; i < 8; i++) begin
          chain_q[i] <= chain_q[i] + round_w[i];
        end
      end
      if (out_acc) begin
        idx_q <= idx_q + 3'd1;
        // Reinitialize for the next message after the final word.
        if (idx_q == sha_pkg::WordLast) begin
          chain_q <= sha_pkg::InitChain;
          cnt_q   <= '0;
        end
      end
    end
  end

  a_out_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !in_i.ready)
    else $error("input taken while digest pending");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_o.last_word) |=> (cnt_q == '0 && fill_q == '0 && idx_q == '0))
    else $error("counters not cleared after digest");

  a_done_in_comp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_stat.done |-> state_q == sha_pkg::ST_COMP)
    else $error("round unit finished outside compression wait");

  a_out_block_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sha_pkg::ST_OUT |-> (fill_q == '0 && !core_stat.busy))
    else $error("digest driven with partial block");

endmodule

// ===== dv/tb_sha256_stream_hasher_unit.sv =====
// Self-checking testbench for sha256_stream_hasher_unit: random byte streams in, digests checked.
// Depends on src/sha_if.sv (channel interfaces) and the hasher RTL; holds its own SHA-256 model.
module tb_sha256_stream_hasher_unit;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 200;

  localparam logic [31:0] RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] ChainInit [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_entry_t;

  class digest_scoreboard;
    logic [31:0]   chain [8];
    logic [31:0]   block [16];
    int unsigned   fill;
    logic [60:0]   byte_total;
    digest_entry_t expected_words [$];
    int unsigned   failures;
    int unsigned   words_checked;
    int unsigned   digests;

    function new();
      failures      = 0;
      words_checked = 0;
      digests       = 0;
      restart();
    endfunction

    function void restart();
      chain      = ChainInit;
      fill       = 0;
      byte_total = '0;
    endfunction

    static function logic [31:0] rotr(logic [31:0] x, int unsigned n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void put_byte(int unsigned pos, logic [7:0] b);
      block[pos / 4][8 * (3 - pos % 4) +: 8] = b;
    endfunction

    function void compress();
      logic [31:0] sched [64];
      logic [31:0] v [8];
      logic [31:0] s0, s1, t1, t2, ch, maj;
      for (int t = 0; t < 16; t++) sched[t] = block[t];
      for (int t = 16; t < 64; t++) begin
        s0 = rotr(sched[t-15], 7) ^ rotr(sched[t-15], 18) ^ (sched[t-15] >> 3);
        s1 = rotr(sched[t-2], 17) ^ rotr(sched[t-2], 19) ^ (sched[t-2] >> 10);
        sched[t] = sched[t-16] + s0 + sched[t-7] + s1;
      end
      v = chain;
      for (int t = 0; t < 64; t++) begin
        s1  = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
        ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
        t1  = v[7] + s1 + ch + RoundConst[t] + sched[t];
        s0  = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
        maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
        t2  = s0 + maj;
        v[7] = v[6];
        v[6] = v[5];
        v[5] = v[4];
        v[4] = v[3] + t1;
        v[3] = v[2];
        v[2] = v[1];
        v[1] = v[0];
        v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
    endfunction

    // Fold one accepted request into the hash state; queue a digest on end of message.
    function void absorb_request(logic [7:0] b, logic bv, logic eom);
      logic [63:0]   bit_len;
      digest_entry_t word_rec;
      if (bv) begin
        put_byte(fill, b);
        byte_total++;
        fill = (fill + 1) % 64;
        if (fill == 0) compress();
      end
      if (!eom) return;
      bit_len = {byte_total, 3'b000};
      put_byte(fill, 8'h80);
      fill++;
      // no room for the length: flush this block and pad a fresh one
      if (fill > 56) begin
        while (fill < 64) begin
          put_byte(fill, 8'h00);
          fill++;
        end
        compress();
        fill = 0;
      end
      while (fill < 56) begin
        put_byte(fill, 8'h00);
        fill++;
      end
      block[14] = bit_len[63:32];
      block[15] = bit_len[31:0];
      compress();
      for (int i = 0; i < 8; i++) begin
        word_rec.word  = chain[i];
        word_rec.index = 3'(i);
        word_rec.last  = (i == 7);
        expected_words = {expected_words, word_rec};
      end
      digests++;
      restart();
    endfunction

    function void check_word(logic [31:0] word, logic [2:0] index, logic last);
      digest_entry_t want;
      if (expected_words.size() == 0) begin
        $error("digest word %08h at index %0d with no digest pending", word, index);
        failures++;
        return;
      end
      want = expected_words.pop_front();
      words_checked++;
      if (word !== want.word) begin
        $error("digest_word: expected %08h, got %08h", want.word, word);
        failures++;
      end
      if (index !== want.index) begin
        $error("word_index: expected %0d, got %0d", want.index, index);
        failures++;
      end
      if (last !== want.last) begin
        $error("last_word: expected %0b, got %0b", want.last, last);
        failures++;
      end
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  sha_in_if  in_if ();
  sha_out_if out_if ();

  sha256_stream_hasher_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #2 clk_i = ~clk_i;

  digest_scoreboard sb;
  int unsigned      requests_sent;
  int unsigned      cycle_count;
  int unsigned      rx_stall;
  bit               calm;
  int unsigned      boundary_lens [$];

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    while (cycle_count < CycleLimit) @(posedge clk_i);
    $display("tb_sha256_stream_hasher_unit: FAIL");
    $finish;
  end

  // Switch at random between stretches with no idling and stretches with random gaps.
  initial begin
    calm = 1'b0;
    forever begin
      repeat ($urandom_range(150, 500)) @(posedge clk_i);
      calm <= ($urandom_range(0, 2) == 0);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 9);
    if (r < 5) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Digest side: check on every accepted word, stall ready at random.
  initial begin
    rx_stall = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1)
        sb.check_word(out_if.digest_word, out_if.word_index, out_if.last_word);
      if (rx_stall == 0 && $urandom_range(0, 3) == 0) rx_stall = pick_gap();
      out_if.ready <= (rx_stall == 0);
      if (rx_stall > 0) rx_stall--;
    end
  end

  task automatic send_request(input logic [7:0] b, input logic bv, input logic eom);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.data_byte      <= b;
    in_if.byte_valid     <= bv;
    in_if.end_of_message <= eom;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    sb.absorb_request(b, bv, eom);
    requests_sent++;
  endtask

  // Random bytes with idle requests mixed in; end mark rides on the last byte or is a bare request.
  task automatic send_message(input int unsigned len);
    bit tail;
    tail = (len > 0) && ($urandom_range(0, 1) == 1);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) send_request(8'($urandom), 1'b0, 1'b0);
      send_request(8'($urandom), 1'b1, tail && (i == len - 1));
    end
    if (!tail) send_request(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    int unsigned len;
    int unsigned pick;
    sb            = new();
    requests_sent = 0;
    cycle_count   = 0;
    in_if.valid          <= 1'b0;
    in_if.data_byte      <= 8'h00;
    in_if.byte_valid     <= 1'b0;
    in_if.end_of_message <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle request, empty messages, single-byte and short messages
    send_request(8'hA5, 1'b0, 1'b0);
    send_request(8'hFF, 1'b0, 1'b1);
    send_request(8'h00, 1'b0, 1'b1);
    send_request(8'h61, 1'b1, 1'b0);
    send_request(8'h62, 1'b1, 1'b0);
    send_request(8'h63, 1'b1, 1'b0);
    send_request(8'h00, 1'b0, 1'b1);
    send_request(8'hFF, 1'b1, 1'b1);
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'hFF, 1'b1, 1'b0);
    send_request(8'h80, 1'b1, 1'b1);
    send_request(8'h5A, 1'b0, 1'b0);
    send_request(8'h00, 1'b1, 1'b1);

    // random messages; lengths at the padding and block boundaries go in once each
    boundary_lens = '{55, 56, 64};
    while (requests_sent < 170 || boundary_lens.size() > 0) begin
      if (boundary_lens.size() > 0 && $urandom_range(0, 3) != 0) begin
        pick = $urandom_range(0, boundary_lens.size() - 1);
        len  = boundary_lens[pick];
        boundary_lens.delete(pick);
      end else if ($urandom_range(0, 5) == 0) begin
        len = $urandom_range(13, 30);
      end else begin
        len = $urandom_range(0, 12);
      end
      send_message(len);
    end
    in_if.valid <= 1'b0;

    while (sb.expected_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Hashed %0d messages from %0d requests, idle ones included,",
             sb.digests, requests_sent);
    $display("including empty and block-boundary lengths; %0d digest words compared",
             sb.words_checked);
    if (sb.failures == 0 && sb.expected_words.size() == 0) begin
      $display("tb_sha256_stream_hasher_unit: PASS");
    end else begin
      $display("tb_sha256_stream_hasher_unit: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/sha_pkg.sv
src/sha_if.sv
src/sha_core.sv
src/sha256_stream_hasher_unit.sv
dv/tb_sha256_stream_hasher_unit.sv
